### rtl/core/ppm_pkg.sv
package ppm_pkg;

    // Store geometry
    localparam int CHANNELS = 8;
    localparam int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Field widths
    localparam int TIME_W = 16;
    localparam int CHI_W  = 8;
    localparam int THR_W  = 12;
    localparam int RCH_W  = 3;
    localparam int GOOD_W = 4;

    // Gap limits in timer ticks
    localparam logic [TIME_W-1:0] SYNC_GAP  = 16'd2700;
    localparam logic [TIME_W-1:0] MIN_PULSE = 16'd750;
    localparam logic [TIME_W-1:0] MAX_PULSE = 16'd2250;

    localparam logic [GOOD_W-1:0] GOOD_ALL        = 4'h F;
    localparam logic [THR_W-1:0]  THRESHOLD_RESET = 12'd985;

    // Command codes
    localparam logic CMD_EDGE = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef struct packed {
        logic              command;
        logic [TIME_W-1:0] edge_time;
        logic [RCH_W-1:0]  read_channel;
    } t_in_item;

    typedef struct packed {
        logic [TIME_W-1:0] channel_width;
        logic              frame_sync;
        logic              failsafe_clear;
        logic              four_good;
    } t_out_item;

endpackage

### rtl/core/ppm_in_if.sv
interface ppm_in_if;
    logic                      valid;
    logic                      ready;
    logic                      command;
    logic [ppm_pkg::TIME_W-1:0] edge_time;
    logic [ppm_pkg::RCH_W-1:0]  read_channel;

    modport source (output valid, output command, output edge_time, output read_channel,
                    input ready);
    modport sink   (input valid, input command, input edge_time, input read_channel,
                    output ready);
endinterface

### rtl/core/ppm_out_if.sv
interface ppm_out_if;
    logic                       valid;
    logic                       ready;
    logic [ppm_pkg::TIME_W-1:0] channel_width;
    logic                       frame_sync;
    logic                       failsafe_clear;
    logic                       four_good;

    modport source (output valid, output channel_width, output frame_sync,
                    output failsafe_clear, output four_good, input ready);
    modport sink   (input valid, input channel_width, input frame_sync,
                    input failsafe_clear, input four_good, output ready);
endinterface

### rtl/core/ppm_in_reg.sv
module ppm_in_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ppm_in_if.sink            i_item,
    input  logic              i_advance,
    output logic              o_valid,
    output ppm_pkg::t_in_item o_item
);
    import ppm_pkg::*;

    logic     r_valid;
    t_in_item r_item;

    // Take a new item when empty or when the held one moves on
    assign i_item.ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_valid <= i_item.valid;
        end
    end

    // Hold payload unless a new item is taken
    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_item.command      <= i_item.command;
            r_item.edge_time    <= i_item.edge_time;
            r_item.read_channel <= i_item.read_channel;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;
endmodule

### rtl/core/ppm_decode.sv
module ppm_decode (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [ppm_pkg::THR_W-1:0] i_cfg_data,
    input  logic                      i_advance,
    input  ppm_pkg::t_in_item         i_item,
    output ppm_pkg::t_out_item        o_result
);
    import ppm_pkg::*;

    logic [THR_W-1:0]  r_threshold;
    logic [TIME_W-1:0] r_prev;
    logic [TIME_W-1:0] n_prev;
    logic [CHI_W-1:0]  r_index;
    logic [CHI_W-1:0]  n_index;
    logic [GOOD_W-1:0] r_good;
    logic [GOOD_W-1:0] n_good;
    logic [TIME_W-1:0] r_store [CHANNELS];

    logic [TIME_W-1:0] gap;
    logic [CHI_W-1:0]  rd_ext;
    logic [GOOD_W-1:0] mask_set;
    logic              store_we;
    t_out_item         result;

    assign gap    = i_item.edge_time - r_prev;
    assign rd_ext = CHI_W'(i_item.read_channel);

    // Decode one item against the current state
    always_comb begin
        n_prev   = r_prev;
        n_index  = r_index;
        n_good   = r_good;
        store_we = 1'b0;
        mask_set = r_good;
        result   = '0;
        case (i_item.command)
            CMD_READ: begin
                if (rd_ext < CHI_W'(CHANNELS)) begin
                    result.channel_width = r_store[rd_ext[IDX_W-1:0]];
                end
            end
            CMD_EDGE: begin
                n_prev = i_item.edge_time;
                if (gap > SYNC_GAP) begin
                    n_index           = '0;
                    result.frame_sync = 1'b1;
                end else begin
                    if (gap > MIN_PULSE && gap < MAX_PULSE
                        && r_index < CHI_W'(CHANNELS)) begin
                        store_we = 1'b1;
                        if (r_index < CHI_W'(GOOD_W)
                            && gap > TIME_W'(r_threshold)) begin
                            mask_set[r_index[1:0]] = 1'b1;
                        end
                        if (mask_set == GOOD_ALL) begin
                            n_good           = '0;
                            result.four_good = 1'b1;
                        end else begin
                            n_good = mask_set;
                        end
                    end
                    n_index               = r_index + 1'b1;
                    result.failsafe_clear = 1'b1;
                end
            end
            default: begin
                result = '0;
            end
        endcase
    end

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RESET;
        end else if (i_cfg_we) begin
            r_threshold <= i_cfg_data;
        end
    end

    // Advance decoder state as the item moves to the result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= '0;
            r_index <= '0;
            r_good  <= '0;
        end else if (i_advance) begin
            r_prev  <= n_prev;
            r_index <= n_index;
            r_good  <= n_good;
        end
    end

    // Pulse width store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < CHANNELS; k++) begin
                r_store[k] <= '0;
            end
        end else if (i_advance && store_we) begin
            r_store[r_index[IDX_W-1:0]] <= gap;
        end
    end

    assign o_result = result;
endmodule

### rtl/core/ppm_out_reg.sv
module ppm_out_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  ppm_pkg::t_out_item i_result,
    output logic               o_can_load,
    ppm_out_if.source          o_result
);
    import ppm_pkg::*;

    logic      r_valid;
    t_out_item r_result;

    // Room when empty or when the held item is taken this cycle
    assign o_can_load = !r_valid || o_result.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_can_load) begin
            r_result <= i_result;
        end
    end

    assign o_result.valid          = r_valid;
    assign o_result.channel_width  = r_result.channel_width;
    assign o_result.frame_sync     = r_result.frame_sync;
    assign o_result.failsafe_clear = r_result.failsafe_clear;
    assign o_result.four_good      = r_result.four_good;
endmodule

### rtl/core/ppm_frame_decoder.sv
// PPM sum signal decoder.
// i_item carries either an edge event (command 0, with the 16-bit timer value
// of the edge) or a read request (command 1, with the channel to read).
// Each item gives exactly one result item on o_result: the stored width on a
// read, or the sync, failsafe-clear and four-good flags on an edge.
// i_cfg_we / i_cfg_data write the 12-bit failsafe threshold; write it only
// while no item is in flight.
// Flow: an accepted item is held in the input register, decoded from there,
// and its result is loaded into the result register as the item moves on.
// One item is accepted per cycle while the receiver takes results; the single
// decode stage between the input and result registers sets that rate.
// Reset (synchronous, active low) clears the previous edge time, the channel
// index, the good mask and all stored widths, and sets the threshold to 985.
// When the receiver stalls, the result register holds its item and the input
// register takes one more item; after that i_item.ready drops until the
// result is taken.
module ppm_frame_decoder (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    ppm_in_if.sink                    i_item,
    ppm_out_if.source                 o_result,
    input  logic                      i_cfg_we,
    input  logic [ppm_pkg::THR_W-1:0] i_cfg_data
);
    import ppm_pkg::*;

    logic      in_valid;
    t_in_item  in_item;
    t_out_item result;
    logic      can_load;
    logic      advance;

    // Move the held item on when the result stage has room
    assign advance = in_valid && can_load;

    ppm_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (i_item),
        .i_advance (advance),
        .o_valid   (in_valid),
        .o_item    (in_item)
    );

    ppm_decode u_decode (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_advance  (advance),
        .i_item     (in_item),
        .o_result   (result)
    );

    ppm_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (advance),
        .i_result   (result),
        .o_can_load (can_load),
        .o_result   (o_result)
    );
endmodule

### bench/testbench.sv
module testbench;
    import ppm_pkg::*;

    // Expected-result tracker: decodes every accepted item on its own copy of the state
    class ppm_decode_board;
        logic [THR_W-1:0]  threshold;
        logic [TIME_W-1:0] last_edge;
        logic [CHI_W-1:0]  chan_idx;
        logic [GOOD_W-1:0] good_bits;
        logic [TIME_W-1:0] widths [CHANNELS];
        t_out_item         pending_decodes [$];
        int                errors;

        function new();
            threshold = THRESHOLD_RESET;
            last_edge = '0;
            chan_idx  = '0;
            good_bits = '0;
            errors    = 0;
            for (int k = 0; k < CHANNELS; k++) begin
                widths[k] = '0;
            end
        endfunction

        // Decode one accepted item and queue the result it must produce
        function void note_item(t_in_item it);
            t_out_item         r;
            logic [TIME_W-1:0] gap;
            r = '0;
            if (it.command == CMD_READ) begin
                if (it.read_channel < CHANNELS) begin
                    r.channel_width = widths[it.read_channel];
                end
            end else begin
                gap       = it.edge_time - last_edge;
                last_edge = it.edge_time;
                if (gap > SYNC_GAP) begin
                    chan_idx     = '0;
                    r.frame_sync = 1'b1;
                end else begin
                    // store only pulses inside the window, on a channel that exists
                    if (gap > MIN_PULSE && gap < MAX_PULSE && chan_idx < CHANNELS) begin
                        widths[chan_idx] = gap;
                        if (chan_idx < 4 && gap > {4'd0, threshold}) begin
                            good_bits[chan_idx[1:0]] = 1'b1;
                        end
                        if (good_bits == GOOD_ALL) begin
                            good_bits   = '0;
                            r.four_good = 1'b1;
                        end
                    end
                    // index advances on every non-sync edge and wraps at 8 bits
                    chan_idx         = chan_idx + 8'd1;
                    r.failsafe_clear = 1'b1;
                end
            end
            pending_decodes.push_back(r);
        endfunction

        task report_mismatch(string msg);
            errors++;
            $display("mismatch at %0t: %s", $realtime, msg);
        endtask

        // Compare one taken result with the oldest expectation
        task check_result(t_out_item got);
            t_out_item want;
            if (pending_decodes.size() == 0) begin
                report_mismatch($sformatf("result with nothing pending: %p", got));
                return;
            end
            want = pending_decodes.pop_front();
            if (got.channel_width !== want.channel_width) begin
                report_mismatch($sformatf("channel_width %0d, want %0d",
                                          got.channel_width, want.channel_width));
            end
            if (got.frame_sync !== want.frame_sync) begin
                report_mismatch($sformatf("frame_sync %b, want %b",
                                          got.frame_sync, want.frame_sync));
            end
            if (got.failsafe_clear !== want.failsafe_clear) begin
                report_mismatch($sformatf("failsafe_clear %b, want %b",
                                          got.failsafe_clear, want.failsafe_clear));
            end
            if (got.four_good !== want.four_good) begin
                report_mismatch($sformatf("four_good %b, want %b",
                                          got.four_good, want.four_good));
            end
        endtask
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [THR_W-1:0]  i_cfg_data;

    ppm_in_if  in_ch ();
    ppm_out_if out_ch ();

    ppm_decode_board   board;
    bit                send_quiet;
    bit                recv_quiet;
    bit                hold_long;
    logic [TIME_W-1:0] edge_clock;
    int                items_sent;

    ppm_frame_decoder uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (in_ch),
        .o_result   (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    // Clock
    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Offer one item after a random gap and hold it until it is taken
    task automatic send_item(input t_in_item it);
        int idle;
        idle = send_quiet ? 0 : $urandom_range(0, 13);
        if (idle > 0) begin
            in_ch.valid <= 1'b0;
            repeat (idle) @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.command      <= it.command;
        in_ch.edge_time    <= it.edge_time;
        in_ch.read_channel <= it.read_channel;
        @(posedge i_clk);
        while (in_ch.ready !== 1'b1) @(posedge i_clk);
        board.note_item(it);
        if (it.command == CMD_EDGE) begin
            edge_clock = it.edge_time;
        end
        items_sent++;
    endtask

    task automatic send_edge(input logic [TIME_W-1:0] gap);
        t_in_item it;
        it.command      = CMD_EDGE;
        it.edge_time    = edge_clock + gap;
        it.read_channel = RCH_W'($urandom);
        send_item(it);
    endtask

    task automatic send_read(input logic [RCH_W-1:0] ch);
        t_in_item it;
        it.command      = CMD_READ;
        it.edge_time    = TIME_W'($urandom);
        it.read_channel = ch;
        send_item(it);
    endtask

    // Drop valid and wait until every result is back
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (board.pending_decodes.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_threshold(input logic [THR_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we        <= 1'b0;
        board.threshold = value;
    endtask

    // Channel gap, mostly valid pulses, some on the window and threshold edges
    function automatic logic [TIME_W-1:0] pulse_gap();
        case ($urandom_range(0, 11))
            0: begin
                case ($urandom_range(0, 6))
                    0: return MIN_PULSE;
                    1: return MIN_PULSE + 16'd1;
                    2: return MAX_PULSE - 16'd1;
                    3: return MAX_PULSE;
                    4: return SYNC_GAP;
                    5: return {4'd0, board.threshold};
                    default: return {4'd0, board.threshold} + 16'd1;
                endcase
            end
            1: return TIME_W'($urandom_range(0, 2700));
            default: return TIME_W'($urandom_range(751, 2249));
        endcase
    endfunction

    // One sync gap and a run of channel pulses, with stray items now and then
    task automatic run_frame();
        int       n;
        t_in_item stray;
        send_quiet = ($urandom_range(0, 5) == 0);
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 3)) begin
                stray.command      = 1'($urandom);
                stray.edge_time    = TIME_W'($urandom);
                stray.read_channel = RCH_W'($urandom);
                send_item(stray);
            end
        end
        send_edge(TIME_W'(($urandom_range(0, 3) == 0) ? 2701 : $urandom_range(2701, 65535)));
        n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 12) : CHANNELS;
        repeat (n) begin
            if ($urandom_range(0, 5) == 0) begin
                send_read(RCH_W'($urandom_range(0, 7)));
            end
            send_edge(pulse_gap());
        end
    endtask

    // Result side: random stalls, one long hold-off on request
    initial begin
        t_out_item got;
        int        stall;
        out_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_long) begin
                out_ch.ready <= 1'b0;
                repeat (48) @(posedge i_clk);
                hold_long = 1'b0;
            end
            if ($urandom_range(0, 19) == 0) begin
                recv_quiet = !recv_quiet;
            end
            stall = recv_quiet ? 0 : $urandom_range(0, 13);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (out_ch.valid !== 1'b1) @(posedge i_clk);
            got.channel_width  = out_ch.channel_width;
            got.frame_sync     = out_ch.frame_sync;
            got.failsafe_clear = out_ch.failsafe_clear;
            got.four_good      = out_ch.four_good;
            board.check_result(got);
        end
    end

    // Main sequence
    initial begin
        int               p;
        logic [THR_W-1:0] phase_thr [6];
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_data         = '0;
        in_ch.valid        = 1'b0;
        in_ch.command      = CMD_EDGE;
        in_ch.edge_time    = '0;
        in_ch.read_channel = '0;
        send_quiet         = 1'b0;
        recv_quiet         = 1'b0;
        hold_long          = 1'b0;
        edge_clock         = '0;
        items_sent         = 0;
        board              = new();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty store, first edge from zero, window and sync edges
        send_read(3'd0);
        send_read(3'd7);
        send_edge(16'd0);
        send_edge(16'hFFFF);
        send_edge(16'd751);
        send_edge(16'd2249);
        send_edge(16'd750);
        send_edge(16'd2250);
        send_edge(16'd2700);
        send_edge(16'd2701);
        // pulses at and just above the threshold, mask left partial
        send_edge(16'd985);
        send_edge(16'd986);
        send_edge(16'd1500);
        // full frame: four good pulses, then channels up to and past the store
        send_edge(16'd3000);
        send_edge(16'd1200);
        send_edge(16'd1300);
        send_edge(16'd1400);
        send_edge(16'd2000);
        send_edge(16'd1100);
        send_edge(16'd1200);
        send_edge(16'd1300);
        send_edge(16'd1400);
        send_edge(16'd1600);
        send_read(3'd3);
        send_read(3'd7);
        drain();

        // Random phases, each under its own threshold
        phase_thr[0] = 12'd0;
        phase_thr[1] = 12'd4095;
        phase_thr[2] = THR_W'($urandom_range(0, 4095));
        phase_thr[3] = 12'd1200;
        phase_thr[4] = 12'd2000;
        phase_thr[5] = THRESHOLD_RESET;
        for (p = 0; p < 6; p++) begin
            write_threshold(phase_thr[p]);
            if (p == 2) begin
                // back the block up while items keep coming
                hold_long  = 1'b1;
                send_quiet = 1'b1;
                repeat (12) send_edge(pulse_gap());
            end
            if (p == 3) begin
                // no sync for long enough to wrap the channel index
                repeat (262) begin
                    if ($urandom_range(0, 7) == 0) begin
                        send_read(RCH_W'($urandom_range(0, 7)));
                    end
                    send_edge(pulse_gap());
                end
            end
            while (items_sent < 26 + (p + 1) * 155) begin
                run_frame();
            end
            drain();
        end

        if (board.errors == 0) begin
            $display("ppm_frame_decoder verification clean");
        end else begin
            $display("ppm_frame_decoder verification failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #4000000;
        $display("ppm_frame_decoder verification failed");
        $finish;
    end

endmodule
